>>> rtl/ispf_pkg.sv
// shared types, constants and reason codes for the ingress source spoof filter
// no dependencies; imported by every module of the block
`default_nettype none

package ispf_pkg;

   localparam int PORT_W   = 6;
   localparam int BYTE_W   = 8;
   localparam int MAC_W    = 48;
   localparam int IP_W     = 32;
   localparam int TYPE_W   = 16;
   localparam int OFF_W    = 6;
   localparam int LEN_W    = OFF_W + 1;
   localparam int REASON_W = 4;

   localparam int DEF_PORT_COUNT = 64;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 8;

   localparam logic [OFF_W-1:0]  OFF_MAX      = '1;
   localparam logic [TYPE_W-1:0] TYPE_IPV4    = 16'h0800;
   localparam logic [TYPE_W-1:0] TYPE_ARP     = 16'h0806;
   localparam logic [TYPE_W-1:0] TYPE_QTAG    = 16'h8100;
   localparam logic [TYPE_W-1:0] TYPE_ADTAG   = 16'h88A8;
   localparam logic [LEN_W-1:0]  ETH_HDR_LEN  = 7'd14;
   localparam logic [LEN_W-1:0]  VLAN_HDR_LEN = 7'd18;
   localparam logic [LEN_W-1:0]  IPV4_HDR_LEN = 7'd20;
   localparam logic [LEN_W-1:0]  ARP_LEN      = 7'd28;
   localparam logic [BYTE_W-1:0] ARP_HLN      = 8'd6;
   localparam logic [BYTE_W-1:0] ARP_PLN      = 8'd4;

   typedef enum logic [REASON_W-1:0] {
      RSN_OK         = 4'd0,
      RSN_OTHER_TYPE = 4'd1,
      RSN_SHORT_ETH  = 4'd2,
      RSN_SHORT_VLAN = 4'd3,
      RSN_UNKNOWN    = 4'd4,
      RSN_MAC        = 4'd5,
      RSN_SHORT_IP   = 4'd6,
      RSN_IP         = 4'd7,
      RSN_SHORT_ARP  = 4'd8,
      RSN_ARP_LENS   = 4'd9,
      RSN_ARP_MAC    = 4'd10,
      RSN_ARP_IP     = 4'd11
   } reason_type;

   // fields of one finished frame, as seen after its last byte
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic              vlan;
      logic [TYPE_W-1:0] eth_type;
      logic [MAC_W-1:0]  src_mac;
      logic [IP_W-1:0]   ip_src;
      logic [TYPE_W-1:0] arp_lens;
      logic [MAC_W-1:0]  arp_mac;
      logic [IP_W-1:0]   arp_ip;
   } frame_type;

   // identity entry looked up for the frame's port
   typedef struct packed {
      logic             known;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0]  ip;
   } ident_type;

endpackage

`default_nettype wire

>>> rtl/ispf_parser.sv
// byte parser: tracks the byte offset and captures header fields of a frame
// depends on ispf_pkg
`default_nettype none

module ispf_parser
   import ispf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_en,
   input  wire logic [PORT_W-1:0] port,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              last,
   output frame_type              frame,
   output logic [PORT_W-1:0]      frame_port
);

   logic [OFF_W-1:0]  off_ff, off_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [MAC_W-1:0]  src_mac_ff, src_mac_in;
   logic [TYPE_W-1:0] outer_ff, outer_in;
   logic [TYPE_W-1:0] inner_ff, inner_in;
   logic [IP_W-1:0]   ip_src_ff, ip_src_in;
   logic [TYPE_W-1:0] arp_lens_ff, arp_lens_in;
   logic [MAC_W-1:0]  arp_mac_ff, arp_mac_in;
   logic [IP_W-1:0]   arp_ip_ff, arp_ip_in;

   logic             first;
   logic             vlan;
   logic [OFF_W-1:0] base;
   logic [OFF_W-1:0] rel;
   logic             past_base;

   assign first = (off_ff == '0);

   always_comb begin
      // captured fields restart at the first byte of each frame
      port_in     = first ? port : port_ff;
      src_mac_in  = first ? '0 : src_mac_ff;
      outer_in    = first ? '0 : outer_ff;
      inner_in    = first ? '0 : inner_ff;
      ip_src_in   = first ? '0 : ip_src_ff;
      arp_lens_in = first ? '0 : arp_lens_ff;
      arp_mac_in  = first ? '0 : arp_mac_ff;
      arp_ip_in   = first ? '0 : arp_ip_ff;

      if (off_ff >= 6'd6 && off_ff <= 6'd11) begin
         src_mac_in = {src_mac_in[MAC_W-BYTE_W-1:0], data_byte};
      end
      if (off_ff == 6'd12 || off_ff == 6'd13) begin
         outer_in = {outer_in[TYPE_W-BYTE_W-1:0], data_byte};
      end

      vlan      = (outer_in == TYPE_QTAG) || (outer_in == TYPE_ADTAG);
      base      = vlan ? VLAN_HDR_LEN[OFF_W-1:0] : ETH_HDR_LEN[OFF_W-1:0];
      past_base = (off_ff >= base);
      rel       = off_ff - base;

      if (vlan && (off_ff == 6'd16 || off_ff == 6'd17)) begin
         inner_in = {inner_in[TYPE_W-BYTE_W-1:0], data_byte};
      end
      if (past_base) begin
         if (rel >= 6'd12 && rel <= 6'd15) begin
            ip_src_in = {ip_src_in[IP_W-BYTE_W-1:0], data_byte};
         end
         if (rel == 6'd4 || rel == 6'd5) begin
            arp_lens_in = {arp_lens_in[TYPE_W-BYTE_W-1:0], data_byte};
         end
         if (rel >= 6'd8 && rel <= 6'd13) begin
            arp_mac_in = {arp_mac_in[MAC_W-BYTE_W-1:0], data_byte};
         end
         if (rel >= 6'd14 && rel <= 6'd17) begin
            arp_ip_in = {arp_ip_in[IP_W-BYTE_W-1:0], data_byte};
         end
      end

      // offset saturates so long frames count as 64 bytes
      if (last) begin
         off_in = '0;
      end else if (off_ff == OFF_MAX) begin
         off_in = off_ff;
      end else begin
         off_in = off_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff      <= '0;
         port_ff     <= '0;
         src_mac_ff  <= '0;
         outer_ff    <= '0;
         inner_ff    <= '0;
         ip_src_ff   <= '0;
         arp_lens_ff <= '0;
         arp_mac_ff  <= '0;
         arp_ip_ff   <= '0;
      end else if (byte_en) begin
         off_ff      <= off_in;
         port_ff     <= port_in;
         src_mac_ff  <= src_mac_in;
         outer_ff    <= outer_in;
         inner_ff    <= inner_in;
         ip_src_ff   <= ip_src_in;
         arp_lens_ff <= arp_lens_in;
         arp_mac_ff  <= arp_mac_in;
         arp_ip_ff   <= arp_ip_in;
      end
   end

   always_comb begin
      frame.len      = LEN_W'(off_ff) + 1'b1;
      frame.vlan     = vlan;
      frame.eth_type = vlan ? inner_in : outer_in;
      frame.src_mac  = src_mac_in;
      frame.ip_src   = ip_src_in;
      frame.arp_lens = arp_lens_in;
      frame.arp_mac  = arp_mac_in;
      frame.arp_ip   = arp_ip_in;
   end

   assign frame_port = port_in;

endmodule

`default_nettype wire

>>> rtl/ispf_ident_table.sv
// per-port identity table: valid flops cleared at reset, mac and ip in memory
// depends on ispf_pkg
`default_nettype none

module ispf_ident_table
   import ispf_pkg::*;
#(
   parameter int PORT_COUNT = DEF_PORT_COUNT
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [PORT_W-1:0] wr_port,
   input  wire logic              wr_valid,
   input  wire logic [MAC_W-1:0]  wr_mac,
   input  wire logic [IP_W-1:0]   wr_ip,
   input  wire logic              rd_en,
   input  wire logic [PORT_W-1:0] rd_port,
   output ident_type              lookup
);

   localparam int IDX_W = $clog2(PORT_COUNT);
   localparam int EXT_W = (IDX_W > PORT_W) ? IDX_W : PORT_W;

   logic [PORT_COUNT-1:0] valid_ff;
   logic [MAC_W-1:0]      mac_mem [PORT_COUNT];
   logic [IP_W-1:0]       ip_mem  [PORT_COUNT];

   logic             known_ff;
   logic [MAC_W-1:0] mac_ff;
   logic [IP_W-1:0]  ip_ff;

   logic [EXT_W-1:0] wr_ext, rd_ext;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic             wr_hit, rd_hit;

   assign wr_ext = EXT_W'(wr_port);
   assign rd_ext = EXT_W'(rd_port);
   assign wr_idx = wr_ext[IDX_W-1:0];
   assign rd_idx = rd_ext[IDX_W-1:0];
   assign wr_hit = (32'(wr_port) < PORT_COUNT);
   assign rd_hit = (32'(rd_port) < PORT_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         known_ff <= 1'b0;
      end else begin
         if (wr_en && wr_hit) begin
            valid_ff[wr_idx] <= wr_valid;
         end
         if (rd_en) begin
            known_ff <= rd_hit && valid_ff[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_hit) begin
         mac_mem[wr_idx] <= wr_mac;
         ip_mem[wr_idx]  <= wr_ip;
      end
      if (rd_en) begin
         mac_ff <= mac_mem[rd_idx];
         ip_ff  <= ip_mem[rd_idx];
      end
   end

   assign lookup.known = known_ff;
   assign lookup.mac   = mac_ff;
   assign lookup.ip    = ip_ff;

endmodule

`default_nettype wire

>>> rtl/ispf_judge.sv
// verdict stage: holds a finished frame, applies the checks, drives the result word
// depends on ispf_pkg
`default_nettype none

module ispf_judge
   import ispf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       frame_done,
   input  wire frame_type  frame,
   input  wire ident_type  lookup,
   output logic            ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_verdict,
   output reason_type      rsp_reason
);

   logic       hold_vld_ff, hold_vld_in;
   frame_type  hold_ff;
   logic       res_vld_ff, res_vld_in;
   logic       verdict_ff;
   reason_type reason_ff;

   logic             res_load;
   reason_type       reason;
   logic [LEN_W-1:0] base;

   assign res_load = hold_vld_ff && (!res_vld_ff || rsp_ready);
   assign ready    = !hold_vld_ff || res_load;

   always_comb begin
      base = hold_ff.vlan ? VLAN_HDR_LEN : ETH_HDR_LEN;
      priority if (hold_ff.len < ETH_HDR_LEN) begin
         reason = RSN_SHORT_ETH;
      end else if (hold_ff.vlan && hold_ff.len < VLAN_HDR_LEN) begin
         reason = RSN_SHORT_VLAN;
      end else if (!lookup.known) begin
         reason = RSN_UNKNOWN;
      end else if (hold_ff.src_mac != lookup.mac) begin
         reason = RSN_MAC;
      end else if (hold_ff.eth_type == TYPE_IPV4) begin
         priority if (hold_ff.len < base + IPV4_HDR_LEN) begin
            reason = RSN_SHORT_IP;
         end else if (hold_ff.ip_src != lookup.ip) begin
            reason = RSN_IP;
         end else begin
            reason = RSN_OK;
         end
      end else if (hold_ff.eth_type == TYPE_ARP) begin
         priority if (hold_ff.len < base + ARP_LEN) begin
            reason = RSN_SHORT_ARP;
         end else if (hold_ff.arp_lens[TYPE_W-1:BYTE_W] != ARP_HLN ||
                      hold_ff.arp_lens[BYTE_W-1:0] != ARP_PLN) begin
            reason = RSN_ARP_LENS;
         end else if (hold_ff.arp_mac != lookup.mac) begin
            reason = RSN_ARP_MAC;
         end else if (hold_ff.arp_ip != lookup.ip) begin
            reason = RSN_ARP_IP;
         end else begin
            reason = RSN_OK;
         end
      end else begin
         reason = RSN_OTHER_TYPE;
      end
   end

   always_comb begin
      priority if (frame_done) begin
         hold_vld_in = 1'b1;
      end else if (res_load) begin
         hold_vld_in = 1'b0;
      end else begin
         hold_vld_in = hold_vld_ff;
      end
      priority if (res_load) begin
         res_vld_in = 1'b1;
      end else if (rsp_ready) begin
         res_vld_in = 1'b0;
      end else begin
         res_vld_in = res_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         res_vld_ff  <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         hold_ff <= frame;
      end
      if (res_load) begin
         verdict_ff <= (reason == RSN_OK) || (reason == RSN_OTHER_TYPE);
         reason_ff  <= reason;
      end
   end

   assign rsp_valid   = res_vld_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_reason  = reason_ff;

endmodule

`default_nettype wire

>>> rtl/ingress_source_spoof_filter.sv
// top level of the ingress source spoof filter: stream ports, parser, table, verdict
// depends on ispf_pkg, ispf_parser, ispf_ident_table, ispf_judge
//
//   channel | side   | tdata                                            | side bits
//   req     | slave  | port, data_byte, entry_valid, entry_mac, entry_ip| tuser action, tlast
//   rsp     | master | verdict, reason                                  | -
//
// one request word per cycle sustained while req_tready is high; a verdict leaves after the
// last byte is taken (parse and table read, then the check into the result register)
// a held frame plus the result register give two verdicts of buffering; req_tready
// drops only while both are full and rsp_tready is low
// synchronous reset clears the valid marks of the whole table
`default_nettype none

module ingress_source_spoof_filter
   import ispf_pkg::*;
#(
   parameter int PORT_COUNT = DEF_PORT_COUNT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [5:0] port, [13:6] data_byte, [14] entry_valid, [62:15] entry_mac,
   // [94:63] entry_ip, [95] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   // [0] action: 0 frame byte, 1 table write
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] verdict, [4:1] reason, [7:5] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic              req_take;
   logic              byte_en;
   logic              wr_en;
   logic              frame_done;
   logic [PORT_W-1:0] req_port;
   frame_type         frame;
   logic [PORT_W-1:0] frame_port;
   ident_type         lookup;
   logic              verdict;
   reason_type        reason;

   assign req_take   = req_tvalid && req_tready;
   assign byte_en    = req_take && !req_tuser;
   assign wr_en      = req_take && req_tuser;
   assign frame_done = byte_en && req_tlast;
   assign req_port   = req_tdata[5:0];

   ispf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (byte_en),
      .port       (req_port),
      .data_byte  (req_tdata[13:6]),
      .last       (req_tlast),
      .frame      (frame),
      .frame_port (frame_port)
   );

   ispf_ident_table #(
      .PORT_COUNT (PORT_COUNT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_port  (req_port),
      .wr_valid (req_tdata[14]),
      .wr_mac   (req_tdata[62:15]),
      .wr_ip    (req_tdata[94:63]),
      .rd_en    (frame_done),
      .rd_port  (frame_port),
      .lookup   (lookup)
   );

   ispf_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .frame_done  (frame_done),
      .frame       (frame),
      .lookup      (lookup),
      .ready       (req_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_verdict (verdict),
      .rsp_reason  (reason)
   );

   assign rsp_tdata = {3'b000, reason, verdict};

endmodule

`default_nettype wire

>>> rtl/ispf_checker.sv
// port-level checks for the ingress source spoof filter, bound to the top level
// depends on ispf_pkg and ingress_source_spoof_filter
`default_nettype none

module ispf_checker
   import ispf_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tlast,
   input wire logic                  req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [REASON_W-1:0] rsn;
   logic                last_take;

   assign rsn       = rsp_tdata[4:1];
   assign last_take = req_tvalid && req_tready && req_tlast && !req_tuser;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsn <= RSN_ARP_IP)
      else $error("reason code out of range");

   // pass exactly for ok and for other ethertypes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsn == RSN_OK || rsn == RSN_OTHER_TYPE))
      else $error("verdict does not match reason");

   // a fresh result follows a taken last frame byte, through the held frame and the result register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(last_take, 2))
      else $error("result without a finished frame");

endmodule

bind ingress_source_spoof_filter ispf_checker u_ispf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for ingress_source_spoof_filter: frame bytes and table writes in,
// pass/drop verdicts out, checked against an in-bench model of the table and the frame parser
// depends on ispf_pkg and the rtl of the block
module testbench;
   import ispf_pkg::*;

   typedef struct {
      bit               pause;        // hold the sender until all verdicts are back
      bit               action;
      logic [PORT_W-1:0] port;
      logic [BYTE_W-1:0] data_byte;
      bit               last;
      bit               entry_valid;
      logic [MAC_W-1:0] entry_mac;
      logic [IP_W-1:0]  entry_ip;
   } req_word_t;

   typedef struct {
      bit         allow;
      reason_type reason;
   } verdict_t;

   typedef enum {KIND_IPV4, KIND_ARP, KIND_OTHER} frame_kind_t;
   typedef enum {TAG_NONE, TAG_Q, TAG_AD, TAG_DOUBLE} tag_t;
   typedef enum {
      FAULT_NONE, FAULT_MAC, FAULT_IP, FAULT_LENS, FAULT_ARP_MAC, FAULT_ARP_IP
   } frame_fault_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   ingress_source_spoof_filter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   req_word_t   stim_words[$];
   verdict_t    pending_verdicts[$];
   req_word_t   cur_word;
   bit          req_taken;
   int          words_taken;
   int          words_built;
   int          mismatches;
   logic [7:0]  frame_bytes[$];

   // generator view of what has been provisioned, used to build matching frames
   bit               prov_valid[64];
   logic [MAC_W-1:0] prov_mac[64];
   logic [IP_W-1:0]  prov_ip[64];

   // model of the block
   bit                id_valid[64];
   logic [MAC_W-1:0]  id_mac[64];
   logic [IP_W-1:0]   id_ip[64];
   logic [OFF_W-1:0]  offset;
   logic [PORT_W-1:0] cur_port;
   logic [MAC_W-1:0]  src_mac;
   logic [TYPE_W-1:0] outer_type;
   logic [TYPE_W-1:0] inner_type;
   logic [IP_W-1:0]   ip_src;
   logic [TYPE_W-1:0] arp_lens;
   logic [MAC_W-1:0]  arp_mac;
   logic [IP_W-1:0]   arp_ip;

   wire steady = words_taken >= 700 && words_taken < 1100;

   function automatic bit is_tagged();
      return outer_type == TYPE_QTAG || outer_type == TYPE_ADTAG;
   endfunction

   function automatic void capture_byte(int off, logic [7:0] b);
      int base;
      int rel;
      if (off >= 6 && off <= 11) src_mac = {src_mac[39:0], b};
      if (off == 12 || off == 13) outer_type = {outer_type[7:0], b};
      if (off < 14) return;
      if (is_tagged() && (off == 16 || off == 17)) inner_type = {inner_type[7:0], b};
      base = is_tagged() ? 18 : 14;
      if (off < base) return;
      rel = off - base;
      if (rel >= 12 && rel <= 15) ip_src = {ip_src[23:0], b};
      if (rel == 4 || rel == 5) arp_lens = {arp_lens[7:0], b};
      if (rel >= 8 && rel <= 13) arp_mac = {arp_mac[39:0], b};
      if (rel >= 14 && rel <= 17) arp_ip = {arp_ip[23:0], b};
   endfunction

   function automatic reason_type frame_reason(int len);
      int base;
      logic [TYPE_W-1:0] etype;
      if (len < ETH_HDR_LEN) return RSN_SHORT_ETH;
      if (is_tagged() && len < VLAN_HDR_LEN) return RSN_SHORT_VLAN;
      if (!id_valid[cur_port]) return RSN_UNKNOWN;
      if (src_mac != id_mac[cur_port]) return RSN_MAC;
      base = is_tagged() ? VLAN_HDR_LEN : ETH_HDR_LEN;
      etype = is_tagged() ? inner_type : outer_type;
      if (etype == TYPE_IPV4) begin
         if (len < base + IPV4_HDR_LEN) return RSN_SHORT_IP;
         if (ip_src != id_ip[cur_port]) return RSN_IP;
         return RSN_OK;
      end
      if (etype == TYPE_ARP) begin
         if (len < base + ARP_LEN) return RSN_SHORT_ARP;
         if (arp_lens[15:8] != ARP_HLN || arp_lens[7:0] != ARP_PLN) return RSN_ARP_LENS;
         if (arp_mac != id_mac[cur_port]) return RSN_ARP_MAC;
         if (arp_ip != id_ip[cur_port]) return RSN_ARP_IP;
         return RSN_OK;
      end
      return RSN_OTHER_TYPE;
   endfunction

   // update the table or the frame capture for one accepted word, queue a verdict on last
   function automatic void track_frame_word(req_word_t w);
      int off;
      verdict_t v;
      if (w.action) begin
         id_valid[w.port] = w.entry_valid;
         id_mac[w.port]   = w.entry_mac;
         id_ip[w.port]    = w.entry_ip;
         return;
      end
      off = offset;
      if (off == 0) begin
         cur_port   = w.port;
         src_mac    = '0;
         outer_type = '0;
         inner_type = '0;
         ip_src     = '0;
         arp_lens   = '0;
         arp_mac    = '0;
         arp_ip     = '0;
      end
      if (off < OFF_MAX) capture_byte(off, w.data_byte);
      if (!w.last) begin
         if (offset != OFF_MAX) offset = offset + 1'b1;
         return;
      end
      v.reason = frame_reason(off + 1);
      v.allow  = v.reason == RSN_OK || v.reason == RSN_OTHER_TYPE;
      offset   = '0;
      pending_verdicts.push_back(v);
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [31:0] hi;
      logic [31:0] lo;
      hi = $urandom;
      lo = $urandom;
      return {hi[15:0], lo};
   endfunction

   function automatic void put_bytes(logic [63:0] v, int n);
      int i;
      for (i = n - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void add_write(int port, bit valid, logic [MAC_W-1:0] mac,
                                     logic [IP_W-1:0] ip);
      req_word_t w;
      w.pause       = 0;
      w.action      = 1;
      w.port        = port;
      w.data_byte   = rand_byte();
      w.last        = $urandom_range(1);
      w.entry_valid = valid;
      w.entry_mac   = mac;
      w.entry_ip    = ip;
      stim_words.push_back(w);
      prov_valid[port] = valid;
      prov_mac[port]   = mac;
      prov_ip[port]    = ip;
      words_built++;
   endfunction

   function automatic void add_pause();
      req_word_t w;
      w = '{default: 0};
      w.pause = 1;
      stim_words.push_back(w);
   endfunction

   // turn frame_bytes into words; non-first words carry a random port, which must be ignored
   function automatic void emit_frame(int port, int write_at);
      req_word_t w;
      int i;
      int tgt;
      bit valid;
      for (i = 0; i < frame_bytes.size(); i++) begin
         w.pause       = 0;
         w.action      = 0;
         w.port        = (i == 0) ? port : $urandom_range(63);
         w.data_byte   = frame_bytes[i];
         w.last        = i == frame_bytes.size() - 1;
         w.entry_valid = $urandom_range(1);
         w.entry_mac   = rand_mac();
         w.entry_ip    = $urandom;
         stim_words.push_back(w);
         words_built++;
         // table write in the middle of a frame
         if (i == write_at && !w.last) begin
            tgt   = $urandom_range(1) ? port : $urandom_range(63);
            valid = $urandom_range(3) != 0;
            if (prov_valid[tgt])
               add_write(tgt, valid, prov_mac[tgt], prov_ip[tgt]);
            else
               add_write(tgt, valid, rand_mac(), $urandom);
         end
      end
   endfunction

   function automatic void add_raw_frame(int port, int n);
      frame_bytes.delete();
      repeat (n) frame_bytes.push_back(rand_byte());
      emit_frame(port, -1);
   endfunction

   function automatic void add_frame(int port, frame_kind_t kind, tag_t tag,
                                     frame_fault_t fault, int pad, int cut, int write_at);
      logic [MAC_W-1:0] mac;
      logic [TYPE_W-1:0] lens;
      frame_bytes.delete();
      put_bytes(rand_mac(), 6);
      put_bytes((fault == FAULT_MAC) ? rand_mac() : prov_mac[port], 6);
      case (tag)
         TAG_Q: begin
            put_bytes(TYPE_QTAG, 2);
            put_bytes($urandom, 2);
         end
         TAG_AD: begin
            put_bytes(TYPE_ADTAG, 2);
            put_bytes($urandom, 2);
         end
         TAG_DOUBLE: begin
            // second tag shows up as the inner type and must count as other type
            put_bytes(TYPE_ADTAG, 2);
            put_bytes($urandom, 2);
            put_bytes(TYPE_QTAG, 2);
            put_bytes($urandom, 2);
         end
         default: ;
      endcase
      case (kind)
         KIND_IPV4: begin
            put_bytes(TYPE_IPV4, 2);
            put_bytes(8'h45, 1);
            repeat (11) frame_bytes.push_back(rand_byte());
            put_bytes((fault == FAULT_IP) ? $urandom : prov_ip[port], 4);
            put_bytes($urandom, 4);
         end
         KIND_ARP: begin
            put_bytes(TYPE_ARP, 2);
            put_bytes(16'h0001, 2);
            put_bytes(TYPE_IPV4, 2);
            lens = {ARP_HLN, ARP_PLN};
            if (fault == FAULT_LENS) begin
               if ($urandom_range(1)) lens[15:8] = rand_byte();
               else lens[7:0] = rand_byte();
            end
            put_bytes(lens, 2);
            put_bytes($urandom_range(2, 1), 2);
            mac = (fault == FAULT_ARP_MAC) ? rand_mac() : prov_mac[port];
            put_bytes(mac, 6);
            put_bytes((fault == FAULT_ARP_IP) ? $urandom : prov_ip[port], 4);
            put_bytes(rand_mac(), 6);
            put_bytes($urandom, 4);
         end
         default: begin
            put_bytes($urandom, 2);
            repeat ($urandom_range(20)) frame_bytes.push_back(rand_byte());
         end
      endcase
      repeat (pad) frame_bytes.push_back(rand_byte());
      if (cut > 0)
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      emit_frame(port, write_at);
   endfunction

   function automatic int pick_port();
      int p;
      p = $urandom_range(63);
      repeat (8) begin
         if (prov_valid[p]) return p;
         p = $urandom_range(63);
      end
      return p;
   endfunction

   function automatic void add_random_stimulus();
      int r;
      int p;
      frame_kind_t kind;
      tag_t tag;
      frame_fault_t fault;
      for (p = 0; p < 64; p++) add_write(p, (p % 7) != 3, rand_mac(), $urandom);
      while (words_built < 1950) begin
         r = $urandom_range(99);
         if (r < 8) begin
            p = $urandom_range(63);
            case ($urandom_range(19))
               0: add_write(p, 1, '1, '1);
               1: add_write(p, 1, '0, '0);
               default: add_write(p, $urandom_range(9) != 0, rand_mac(), $urandom);
            endcase
         end else if (r < 14) begin
            add_raw_frame($urandom_range(63), $urandom_range(70, 1));
         end else begin
            p = ($urandom_range(9) == 0) ? $urandom_range(63) : pick_port();
            r = $urandom_range(99);
            kind = (r < 40) ? KIND_IPV4 : (r < 80) ? KIND_ARP : KIND_OTHER;
            r = $urandom_range(99);
            tag = (r < 60) ? TAG_NONE : (r < 75) ? TAG_Q : (r < 90) ? TAG_AD : TAG_DOUBLE;
            fault = ($urandom_range(99) < 60) ? FAULT_NONE
                                              : frame_fault_t'($urandom_range(5, 1));
            add_frame(p, kind, tag, fault,
                      ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6),
                      ($urandom_range(99) < 15) ? $urandom_range(40, 1) : 0,
                      ($urandom_range(19) == 0) ? $urandom_range(30) : -1);
         end
         if ($urandom_range(149) == 0 || words_built == 1000) add_pause();
      end
   endfunction

   function automatic void add_directed_stimulus();
      add_frame(5, KIND_IPV4, TAG_NONE, FAULT_NONE, 0, 0, -1);    // nothing provisioned yet
      add_write(0, 1, '0, '0);
      add_write(63, 1, '1, '1);
      add_write(5, 0, rand_mac(), $urandom);
      add_raw_frame(0, 1);
      add_raw_frame(63, 13);
      add_frame(63, KIND_IPV4, TAG_NONE, FAULT_NONE, 0, 0, -1);
      add_frame(0, KIND_ARP, TAG_NONE, FAULT_NONE, 0, 0, -1);
      add_frame(5, KIND_ARP, TAG_NONE, FAULT_NONE, 0, 0, -1);
      add_frame(63, KIND_IPV4, TAG_Q, FAULT_NONE, 0, 17, -1);
      add_frame(63, KIND_IPV4, TAG_AD, FAULT_NONE, 0, 18, -1);
      add_frame(0, KIND_IPV4, TAG_NONE, FAULT_NONE, 0, 33, -1);
      add_frame(0, KIND_IPV4, TAG_NONE, FAULT_NONE, 0, 34, -1);
      add_frame(63, KIND_IPV4, TAG_NONE, FAULT_IP, 2, 0, -1);
      add_frame(63, KIND_IPV4, TAG_Q, FAULT_MAC, 0, 0, -1);
      add_frame(0, KIND_ARP, TAG_NONE, FAULT_NONE, 0, 41, -1);
      add_frame(0, KIND_ARP, TAG_AD, FAULT_LENS, 0, 0, -1);
      add_frame(63, KIND_ARP, TAG_NONE, FAULT_ARP_MAC, 0, 0, -1);
      add_frame(63, KIND_ARP, TAG_Q, FAULT_ARP_IP, 0, 0, -1);
      add_frame(0, KIND_OTHER, TAG_NONE, FAULT_NONE, 0, 14, -1);
      add_frame(63, KIND_IPV4, TAG_DOUBLE, FAULT_NONE, 0, 0, -1);
      add_frame(63, KIND_IPV4, TAG_NONE, FAULT_NONE, 40, 0, -1);  // runs past the byte counter
      add_frame(0, KIND_IPV4, TAG_NONE, FAULT_NONE, 0, 0, 3);
      add_pause();
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // driver: launches the next word at the falling edge once the previous one is taken
   always @(negedge clock) begin
      bit launch;
      rsp_tready = steady || ($urandom_range(99) >= 34);
      if (reset) begin
         req_tvalid = 0;
      end else if (!req_tvalid || req_taken) begin
         if (stim_words.size() != 0 && stim_words[0].pause && pending_verdicts.size() == 0)
            void'(stim_words.pop_front());
         launch = stim_words.size() != 0 && !stim_words[0].pause &&
                  (steady || $urandom_range(99) >= 34);
         if (launch) begin
            cur_word  = stim_words.pop_front();
            req_tdata = {1'b0, cur_word.entry_ip, cur_word.entry_mac, cur_word.entry_valid,
                         cur_word.data_byte, cur_word.port};
            req_tlast = cur_word.last;
            req_tuser = cur_word.action;
         end
         req_tvalid = launch;
      end
   end

   // monitor: feeds taken words to the model and checks each verdict word
   always @(posedge clock) begin
      verdict_t exp;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         track_frame_word(cur_word);
         words_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("verdict word with none expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            exp = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== exp.allow) begin
               $error("verdict: expected %0d, got %0d", exp.allow, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[4:1] !== exp.reason) begin
               $error("reason: expected %0d, got %0d", exp.reason, rsp_tdata[4:1]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tlast   = 0;
      req_tuser   = 0;
      rsp_tready  = 0;
      req_taken   = 0;
      cur_word    = '{default: 0};
      words_taken = 0;
      words_built = 0;
      mismatches  = 0;
      offset      = '0;
      cur_port    = '0;
      for (int i = 0; i < 64; i++) begin
         id_valid[i]   = 0;
         prov_valid[i] = 0;
         prov_mac[i]   = '0;
         prov_ip[i]    = '0;
      end
      add_directed_stimulus();
      add_random_stimulus();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
      while (stim_words.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #400000;
      $display("Some tests failed");
      $finish;
   end

endmodule
